@@ rtl/wave_table_sound_channel_assert.svh @@
// ----------------------------------------------------------------------------
// Wave table sound channel assertion macros
// Shared property forms for the channel checker.
// ----------------------------------------------------------------------------
`ifndef WAVE_TABLE_SOUND_CHANNEL_ASSERT_SVH
`define WAVE_TABLE_SOUND_CHANNEL_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WTSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wtsc check failed");

// next-cycle implication, disabled during reset
`define WTSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wtsc check failed");

`endif

@@ rtl/wtsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wave table sound channel package
// Sizes, operation codes and shared types of the channel.
// ----------------------------------------------------------------------------
package wtsc_pkg;

  // wave RAM size in bytes, a multiple of 4
  localparam int WAVE_BYTES    = 16;
  localparam int TRIGGER_DELAY = 3;

  localparam int WAVE_AW   = $clog2(WAVE_BYTES);
  localparam int POS_W     = WAVE_AW + 1;
  localparam int WAVE_ROWS = WAVE_BYTES / 4;
  localparam int ROW_AW    = (WAVE_AW > 2) ? WAVE_AW - 2 : 1;

  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(2 * WAVE_BYTES - 1);
  localparam logic [11:0]      PERIOD_BASE = 12'h800;
  localparam logic [2:0]       MUTE_SHIFT  = 3'd4;
  localparam logic signed [4:0] LEVEL_LOW  = -5'sd15;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_DAC      = 3'd1,
    OP_VOLUME   = 3'd2,
    OP_FREQ_LO  = 3'd3,
    OP_FREQ_HI  = 3'd4,
    OP_WAVE_WR  = 3'd5
  } wtsc_op_t;

  typedef struct packed {
    logic               wr_en;
    logic [WAVE_AW-1:0] wr_addr;
    logic [7:0]         wr_data;
    logic               copy_en;
    logic [ROW_AW-1:0]  rd_row;
    logic [1:0]         rd_byte;
  } wtsc_ram_ctrl_t;

  typedef struct packed {
    logic signed [4:0] level;
    logic              playing;
    logic              dac_enabled;
  } wtsc_result_t;

endpackage

@@ rtl/wtsc_wave_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wave RAM store
// Byte store in rows of four: byte writes, one row read, row 0 copy.
// ----------------------------------------------------------------------------
module wtsc_wave_store
  import wtsc_pkg::*;
(
  input  logic           clk,
  input  wtsc_ram_ctrl_t ctrl,
  output logic [7:0]     rd_data
);

  logic [7:0] mem [WAVE_ROWS][4];
  logic [7:0] row_rd [4];
  logic [ROW_AW-1:0] wr_row;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      row_rd[i] = mem[ctrl.rd_row][i];
    end
  end

  assign rd_data = row_rd[ctrl.rd_byte];
  assign wr_row  = ROW_AW'(ctrl.wr_addr >> 2);

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_row][ctrl.wr_addr[1:0]] <= ctrl.wr_data;
    end else if (ctrl.copy_en) begin
      if (ctrl.rd_row == '0) begin
        mem[0][0] <= row_rd[ctrl.rd_byte];
      end else begin
        for (int i = 0; i < 4; i++) begin
          mem[0][i] <= row_rd[i];
        end
      end
    end
  end

endmodule

@@ rtl/wtsc_voice.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wave channel voice
// Channel state, per-item update and output level of the channel.
// ----------------------------------------------------------------------------
module wtsc_voice
  import wtsc_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [2:0]     op,
  input  logic [7:0]     data_byte,
  input  logic [3:0]     ram_index,
  input  logic           model_sel,
  input  logic [7:0]     rd_data,
  output wtsc_ram_ctrl_t ram_ctrl,
  output wtsc_result_t   result
);

  logic [POS_W-1:0]   play_position, play_position_next;
  logic [7:0]         sample_latch, sample_latch_next;
  logic [11:0]        period_timer, period_timer_next;
  logic               timer_running, timer_running_next;
  logic               active, active_next;
  logic               dac_on, dac_on_next;
  logic [2:0]         volume_shift, volume_shift_next;
  logic [7:0]         freq_low, freq_low_next;
  logic [2:0]         freq_high, freq_high_next;

  logic [POS_W-1:0]   pos_inc;
  logic [WAVE_AW-1:0] byte_pos;
  logic [11:0]        period_cur;
  logic [11:0]        period_trig;
  logic [3:0]         nib;
  logic [3:0]         nib_shifted;
  logic               wr_hit;
  logic               copy_hit;

  assign pos_inc     = (play_position == POS_LAST) ? '0 : play_position + 1'b1;
  assign byte_pos    = pos_inc[POS_W-1:1];
  assign period_cur  = PERIOD_BASE - {1'b0, freq_high, freq_low};
  assign period_trig = PERIOD_BASE - {1'b0, data_byte[2:0], freq_low};
  assign wr_hit      = ({1'b0, ram_index} < 5'(WAVE_BYTES)) || (WAVE_BYTES > 16);

  always_comb begin
    play_position_next = play_position;
    sample_latch_next  = sample_latch;
    period_timer_next  = period_timer;
    timer_running_next = timer_running;
    active_next        = active;
    dac_on_next        = dac_on;
    volume_shift_next  = volume_shift;
    freq_low_next      = freq_low;
    freq_high_next     = freq_high;
    copy_hit           = 1'b0;
    case (wtsc_op_t'(op))
      OP_TICK: begin
        if (timer_running) begin
          if (period_timer <= 12'd1) begin
            play_position_next = pos_inc;
            sample_latch_next  = rd_data;
            period_timer_next  = period_cur;
          end else begin
            period_timer_next = period_timer - 12'd1;
          end
        end
      end
      OP_DAC: begin
        dac_on_next = data_byte[7];
        if (!data_byte[7]) begin
          active_next        = 1'b0;
          timer_running_next = 1'b0;
          period_timer_next  = '0;
        end
      end
      OP_VOLUME: begin
        volume_shift_next = (data_byte[6:5] == 2'd0) ? MUTE_SHIFT
                                                     : {1'b0, data_byte[6:5] - 2'd1};
      end
      OP_FREQ_LO: begin
        freq_low_next = data_byte;
      end
      OP_FREQ_HI: begin
        freq_high_next = data_byte[2:0];
        if (data_byte[7] && dac_on) begin
          copy_hit           = !model_sel && timer_running && (period_timer == 12'd1);
          active_next        = 1'b1;
          play_position_next = '0;
          timer_running_next = 1'b1;
          period_timer_next  = period_trig + 12'(TRIGGER_DELAY);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ram_ctrl.wr_en   = en && (wtsc_op_t'(op) == OP_WAVE_WR) && wr_hit;
    ram_ctrl.wr_addr = WAVE_AW'(ram_index);
    ram_ctrl.wr_data = data_byte;
    ram_ctrl.copy_en = en && copy_hit;
    ram_ctrl.rd_row  = ROW_AW'(byte_pos >> 2);
    ram_ctrl.rd_byte = byte_pos[1:0];
  end

  assign nib         = play_position_next[0] ? sample_latch_next[3:0]
                                             : sample_latch_next[7:4];
  assign nib_shifted = nib >> volume_shift_next[1:0];

  always_comb begin
    result.playing     = active_next;
    result.dac_enabled = dac_on_next;
    if (!dac_on_next) begin
      result.level = '0;
    end else if (volume_shift_next[2] || !active_next) begin
      result.level = LEVEL_LOW;
    end else begin
      result.level = $signed({nib_shifted, 1'b0}) + LEVEL_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_position <= '0;
      sample_latch  <= '0;
      period_timer  <= '0;
      timer_running <= 1'b0;
      active        <= 1'b0;
      dac_on        <= 1'b0;
      volume_shift  <= MUTE_SHIFT;
      freq_low      <= '0;
      freq_high     <= '0;
    end else if (en) begin
      play_position <= play_position_next;
      sample_latch  <= sample_latch_next;
      period_timer  <= period_timer_next;
      timer_running <= timer_running_next;
      active        <= active_next;
      dac_on        <= dac_on_next;
      volume_shift  <= volume_shift_next;
      freq_low      <= freq_low_next;
      freq_high     <= freq_high_next;
    end
  end

endmodule

@@ rtl/wave_table_sound_channel.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wave table sound channel
// Wave playback channel stepped by one tick or one register write per item.
//
//   channel  signals                           payload
//   item     item_valid / item_ready           op, data_byte, ram_index
//   result   result_valid / result_ready       level, playing, dac_enabled
//   cfg      cfg_valid / cfg_ready             color_model
//
// One item per cycle while results are taken; each item passes the input register,
// then the result register, after its transfer.
// Reset clears the channel state and both stages; wave RAM is not cleared.
// A stalled result holds; the input stage still takes an item while its own
// slot is free or moving on.
// ----------------------------------------------------------------------------
module wave_table_sound_channel
  import wtsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [2:0]        op,
  input  logic [7:0]        data_byte,
  input  logic [3:0]        ram_index,
  output logic              result_valid,
  input  logic              result_ready,
  output logic signed [4:0] level,
  output logic              playing,
  output logic              dac_enabled,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              color_model
);

  logic           stage_valid;
  logic [2:0]     stage_op;
  logic [7:0]     stage_data;
  logic [3:0]     stage_index;
  logic           model_sel;
  logic           advance;
  logic [7:0]     rd_data;
  wtsc_ram_ctrl_t ram_ctrl;
  wtsc_result_t   result;

  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !rst && (!stage_valid || advance);
  assign cfg_ready  = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_op    <= op;
      stage_data  <= data_byte;
      stage_index <= ram_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      model_sel <= 1'b0;
    end else if (cfg_valid) begin
      model_sel <= color_model;
    end
  end

  wtsc_wave_store u_store (
    .clk     (clk),
    .ctrl    (ram_ctrl),
    .rd_data (rd_data)
  );

  wtsc_voice u_voice (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .op        (stage_op),
    .data_byte (stage_data),
    .ram_index (stage_index),
    .model_sel (model_sel),
    .rd_data   (rd_data),
    .ram_ctrl  (ram_ctrl),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      level       <= result.level;
      playing     <= result.playing;
      dac_enabled <= result.dac_enabled;
    end
  end

endmodule

@@ rtl/wtsc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wave table sound channel checker
// Port-level checks on output levels and result hold.
// ----------------------------------------------------------------------------
`include "wave_table_sound_channel_assert.svh"

module wtsc_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input logic signed [4:0] level,
  input logic              playing,
  input logic              dac_enabled
);

  `WTSC_ASSERT_NOW(a_dac_off_silent, result_valid && !dac_enabled, (level == 5'sd0) && !playing)

  `WTSC_ASSERT_NOW(a_level_odd, result_valid && dac_enabled, level[0] && (level != -5'sd16))

  `WTSC_ASSERT_NOW(a_idle_floor, result_valid && dac_enabled && !playing, level == -5'sd15)

  `WTSC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(level) && $stable(playing) && $stable(dac_enabled))

endmodule

bind wave_table_sound_channel wtsc_checker u_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wave table sound channel testbench
// Loads wave RAM, then walks a table of opening items. Some rows carry fixed
// results: reset values, DAC off, mute, and the undefined ops. The rest of
// the table and the random register, wave RAM and tick traffic that follows
// are checked against a channel model kept in the bench. Random traffic runs
// under both the older and the newer model. The sender works in bursts and
// the receiver stalls, once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import wtsc_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int PHASE_ITEMS = 300;
  localparam int LONG_HOLD = 200;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [2:0]   code;
    logic [7:0]   d;
    logic [3:0]   idx;
    logic         typed;
    wtsc_result_t want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  logic [2:0]        op = OP_TICK;
  logic [7:0]        data_byte = 8'h00;
  logic [3:0]        ram_index = 4'h0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic signed [4:0] level;
  logic              playing;
  logic              dac_enabled;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              color_model = 1'b0;

  // channel model state
  logic [7:0]       wave_img [WAVE_BYTES];
  logic [POS_W-1:0] play_pos = '0;
  logic [7:0]       latched_byte = 8'h00;
  logic [11:0]      countdown = 12'h000;
  logic             counting = 1'b0;
  logic             chan_active = 1'b0;
  logic             dac_bit = 1'b0;
  logic [2:0]       shift_amt = MUTE_SHIFT;
  logic [7:0]       freq_lo_reg = 8'h00;
  logic [2:0]       freq_hi_reg = 3'h0;
  logic             newer_model = 1'b0;

  wtsc_result_t due_results [$];
  int unsigned  mismatches = 0;
  int unsigned  burst_left = 1;
  int unsigned  cycles = 0;
  int unsigned  rx_left = 0;
  logic         long_hold_req = 1'b0;
  logic         long_hold_done = 1'b0;

  stim_row_t opening_rows [25] = '{
    '{OP_TICK,    8'h00, 4'h0, 1'b1, '{5'sd0,     1'b0, 1'b0}},
    '{OP_SPARE7,  8'hFF, 4'hF, 1'b1, '{5'sd0,     1'b0, 1'b0}},
    '{OP_FREQ_HI, 8'h87, 4'h0, 1'b1, '{5'sd0,     1'b0, 1'b0}},
    '{OP_DAC,     8'h80, 4'h0, 1'b1, '{LEVEL_LOW, 1'b0, 1'b1}},
    '{OP_VOLUME,  8'h20, 4'h0, 1'b1, '{LEVEL_LOW, 1'b0, 1'b1}},
    '{OP_FREQ_LO, 8'hFF, 4'h0, 1'b1, '{LEVEL_LOW, 1'b0, 1'b1}},
    '{OP_FREQ_HI, 8'h87, 4'h0, 1'b1, '{LEVEL_LOW, 1'b1, 1'b1}},
    '{OP_TICK,    8'h00, 4'h0, 1'b0, '0},
    '{OP_TICK,    8'h00, 4'h0, 1'b0, '0},
    '{OP_TICK,    8'h00, 4'h0, 1'b0, '0},
    '{OP_TICK,    8'h00, 4'h0, 1'b0, '0},
    '{OP_TICK,    8'h00, 4'h0, 1'b0, '0},
    '{OP_TICK,    8'h00, 4'h0, 1'b0, '0},
    '{OP_TICK,    8'h00, 4'h0, 1'b0, '0},
    '{OP_TICK,    8'h00, 4'h0, 1'b0, '0},
    '{OP_TICK,    8'h00, 4'h0, 1'b0, '0},
    '{OP_TICK,    8'h00, 4'h0, 1'b0, '0},
    '{OP_TICK,    8'h00, 4'h0, 1'b0, '0},
    '{OP_VOLUME,  8'h40, 4'h0, 1'b0, '0},
    '{OP_FREQ_HI, 8'hFF, 4'h0, 1'b0, '0},
    '{OP_TICK,    8'h00, 4'h0, 1'b0, '0},
    '{OP_VOLUME,  8'h60, 4'h0, 1'b0, '0},
    '{OP_VOLUME,  8'h9F, 4'h0, 1'b1, '{LEVEL_LOW, 1'b1, 1'b1}},
    '{OP_SPARE6,  8'h00, 4'h0, 1'b1, '{LEVEL_LOW, 1'b1, 1'b1}},
    '{OP_DAC,     8'h7F, 4'h0, 1'b1, '{5'sd0,     1'b0, 1'b0}}
  };

  wave_table_sound_channel uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .op           (op),
    .data_byte    (data_byte),
    .ram_index    (ram_index),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .level        (level),
    .playing      (playing),
    .dac_enabled  (dac_enabled),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .color_model  (color_model)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [11:0] period_reload();
    return PERIOD_BASE - 12'({freq_hi_reg, freq_lo_reg});
  endfunction

  function automatic wtsc_result_t channel_step(input logic [2:0] code, input logic [7:0] d,
                                                input logic [3:0] idx);
    wtsc_result_t r;
    logic [3:0]   nib;
    int           p;
    int           base;
    logic [7:0]   quad [4];
    case (code)
      OP_TICK: begin
        if (counting) begin
          if (countdown <= 12'd1) begin
            play_pos = play_pos + 1'b1;
            latched_byte = wave_img[play_pos[POS_W-1:1]];
            countdown = period_reload();
          end else begin
            countdown = countdown - 12'd1;
          end
        end
      end
      OP_DAC: begin
        dac_bit = d[7];
        if (!d[7]) begin
          chan_active = 1'b0;
          counting = 1'b0;
          countdown = 12'h000;
        end
      end
      OP_VOLUME: begin
        shift_amt = (d[6:5] == 2'd0) ? MUTE_SHIFT : 3'(d[6:5]) - 3'd1;
      end
      OP_FREQ_LO: begin
        freq_lo_reg = d;
      end
      OP_FREQ_HI: begin
        freq_hi_reg = d[2:0];
        if (d[7] && dac_bit) begin
          // older model: retrigger before a due read copies a byte or row
          if (!newer_model && counting && countdown == 12'd1) begin
            p = ((int'(play_pos) + 1) / 2) % WAVE_BYTES;
            if (p < 4) begin
              wave_img[0] = wave_img[p];
            end else begin
              base = p & ~3;
              for (int i = 0; i < 4; i++) quad[i] = wave_img[(base + i) % WAVE_BYTES];
              for (int i = 0; i < 4; i++) wave_img[i] = quad[i];
            end
          end
          chan_active = 1'b1;
          play_pos = '0;
          counting = 1'b1;
          countdown = period_reload() + 12'(TRIGGER_DELAY);
        end
      end
      OP_WAVE_WR: begin
        if (int'(idx) < WAVE_BYTES) wave_img[idx] = d;
      end
      default: begin
      end
    endcase
    r.playing = chan_active;
    r.dac_enabled = dac_bit;
    nib = play_pos[0] ? latched_byte[3:0] : latched_byte[7:4];
    if (!dac_bit) begin
      r.level = 5'sd0;
    end else if (shift_amt >= MUTE_SHIFT || !chan_active) begin
      r.level = LEVEL_LOW;
    end else begin
      r.level = 5'(int'(nib >> shift_amt) * 2 - 15);
    end
    return r;
  endfunction

  task automatic offer_item(input logic [2:0] code, input logic [7:0] d, input logic [3:0] idx,
                            input logic typed, input wtsc_result_t want);
    wtsc_result_t model_out;
    int unsigned  gap;
    item_valid <= 1'b1;
    op <= code;
    data_byte <= d;
    ram_index <= idx;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    model_out = channel_step(code, d, idx);
    due_results.push_back(typed ? want : model_out);
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic set_model(input logic v);
    cfg_valid <= 1'b1;
    color_model <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    newer_model = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [2:0]   code;
    logic [7:0]   d;
    logic [3:0]   idx;
    int unsigned  pick;
    wtsc_result_t none;
    none = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_model(1'b0);
    for (int k = 0; k < WAVE_BYTES; k++) begin
      offer_item(OP_WAVE_WR, 8'($urandom), 4'(k), 1'b0, none);
    end
    foreach (opening_rows[n]) begin
      offer_item(opening_rows[n].code, opening_rows[n].d, opening_rows[n].idx,
                 opening_rows[n].typed, opening_rows[n].want);
    end
    item_valid <= 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      set_model((ph % 2) == 0);
      if (ph == 0) long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        d = 8'($urandom);
        idx = 4'($urandom);
        if (pick < 60) begin
          code = OP_TICK;
        end else if (pick < 68) begin
          code = OP_WAVE_WR;
        end else if (pick < 74) begin
          code = OP_VOLUME;
        end else if (pick < 80) begin
          code = OP_FREQ_LO;
          if ($urandom_range(0, 1) == 1) d = 8'($urandom_range(8'hF8, 8'hFF));
        end else if (pick < 88) begin
          code = OP_FREQ_HI;
          d[7] = ($urandom_range(0, 9) < 7);
          if ($urandom_range(0, 1) == 1) d[2:0] = 3'h7;
        end else if (pick < 93) begin
          code = OP_DAC;
          d[7] = ($urandom_range(0, 9) < 8);
        end else if (pick < 97) begin
          code = ($urandom_range(0, 1) == 1) ? OP_SPARE6 : OP_SPARE7;
        end else begin
          code = OP_TICK;
        end
        offer_item(code, d, idx, 1'b0, none);
      end
      item_valid <= 1'b0;
    end
    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin : receiver
    if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      rx_left <= LONG_HOLD;
      result_ready <= 1'b0;
    end else if (rx_left > 1) begin
      rx_left <= rx_left - 1;
    end else if (result_ready) begin
      if ($urandom_range(0, 3) == 0) begin
        result_ready <= 1'b1;
        rx_left <= $urandom_range(1, 40);
      end else begin
        result_ready <= 1'b0;
        rx_left <= $urandom_range(1, 6);
      end
    end else begin
      result_ready <= 1'b1;
      rx_left <= $urandom_range(1, 30);
    end
  end

  always @(posedge clk) begin : result_check
    wtsc_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing pending: level %0d playing %0b dac %0b",
                 $time, level, playing, dac_enabled);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (level !== want.level) begin
          $display("%0t: level expected %0d got %0d", $time, $signed(want.level), level);
          mismatches++;
        end
        if (playing !== want.playing) begin
          $display("%0t: playing expected %0b got %0b", $time, want.playing, playing);
          mismatches++;
        end
        if (dac_enabled !== want.dac_enabled) begin
          $display("%0t: dac_enabled expected %0b got %0b", $time, want.dac_enabled,
                   dac_enabled);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
